>>> rtl/sawh_pkg.sv
`timescale 1ns / 1ps

package sawh_pkg;

    // width of the shared unit's datapath
    localparam int UW = 192;

    typedef enum logic [2:0] {
        OP_MUL  = 3'b001,
        OP_DIV  = 3'b010,
        OP_SQRT = 3'b100
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } unit_req_t;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_PERIOD    = 1'b1;

    // repulsion: 2^73 * 5^12 / g^5 with g = 125*d + 512
    localparam logic [UW-1:0] REPEL_NUM   = UW'(244140625) << 73;
    localparam logic [63:0]   REPEL_SCALE = 64'd125;
    localparam logic [22:0]   REPEL_BIAS  = 23'd512;
    localparam logic [63:0]   FORCE_SAT   = 64'h0000_0000_FFFF_0000;

    localparam logic [15:0]        PERIOD_RESET = 16'd6000;
    localparam logic signed [32:0] LAST_RESET   = -33'sd10000;

endpackage

>>> rtl/sawh_unit.sv
`timescale 1ns / 1ps

module sawh_unit
    import sawh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  unit_req_t     req,
    input  logic [UW-1:0] opa,
    input  logic [UW-1:0] opb,
    output logic          done,
    output logic [UW-1:0] res
);

    logic          run_reg, run_next;
    op_t           op_reg, op_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [UW-1:0] acc_reg, acc_next;
    logic [UW-1:0] x_reg, x_next;
    logic [63:0]   y_reg, y_next;

    logic [UW-1:0] root_trial;
    logic [UW-1:0] opnd;
    logic [UW-1:0] diff;
    logic          ge;

    // one compare/subtract shared by divide and root steps
    always_comb
    begin
        root_trial = x_reg + {{(UW-64){1'b0}}, y_reg};
        opnd       = (op_reg == OP_SQRT) ? root_trial : x_reg;
        diff       = acc_reg - opnd;
        ge         = (acc_reg >= opnd);
    end

    always_comb
    begin
        run_next  = run_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            run_next = 1'b1;
            op_next  = req.op;
            unique case (req.op)
                OP_MUL:
                begin
                    acc_next = '0;
                    x_next   = opa;
                    y_next   = opb[63:0];
                    cnt_next = '0;
                end
                OP_DIV:
                begin
                    acc_next = opa;
                    x_next   = opb << 63;
                    y_next   = '0;
                    cnt_next = 7'd64;
                end
                OP_SQRT:
                begin
                    acc_next = opa;
                    x_next   = '0;
                    y_next   = 64'd1 << 34;
                    cnt_next = 7'd18;
                end
                default:
                begin
                    run_next = 1'b0;
                end
            endcase
        end
        else if (run_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    // lsb-first shift-add, ends when multiplier runs out
                    if (y_reg == '0)
                    begin
                        run_next  = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (y_reg[0])
                        begin
                            acc_next = acc_reg + x_reg;
                        end
                        x_next = x_reg << 1;
                        y_next = y_reg >> 1;
                    end
                end
                OP_DIV:
                begin
                    if (ge)
                    begin
                        acc_next = diff;
                    end
                    y_next   = {y_reg[62:0], ge};
                    x_next   = x_reg >> 1;
                    cnt_next = cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        run_next  = 1'b0;
                        done_next = 1'b1;
                    end
                end
                OP_SQRT:
                begin
                    if (ge)
                    begin
                        acc_next = diff;
                        x_next   = (x_reg >> 1) + {{(UW-64){1'b0}}, y_reg};
                    end
                    else
                    begin
                        x_next = x_reg >> 1;
                    end
                    y_next   = y_reg >> 2;
                    cnt_next = cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        run_next  = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    run_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    always_comb
    begin
        case (op_reg)
            OP_MUL:  res = acc_reg;
            OP_DIV:  res = {{(UW-64){1'b0}}, y_reg};
            OP_SQRT: res = x_reg;
            default: res = '0;
        endcase
    end

    assign done = done_reg;

endmodule

>>> rtl/sonar_avoid_wander_heading_core.sv
`timescale 1ns / 1ps

// sonar obstacle avoidance with random wander, unit heading out
// input stream: one word carries four sonar distances, a millisecond time and
// a random vector; s_tready is high only while the block is idle
// output stream: one word per input word with heading x/y in q1.14 and a
// flag in tuser that a new wander direction was drawn
// config channel: cfg_index 0 = force threshold (q16.16), 1 = wander period
// in ms; always ready, write only while no word is in flight
// arithmetic: one shared unit does all of it: bit-serial shift-add multiply
// (one multiplier bit per cycle), a 64-step restoring divider and an
// 18-step square root, used in turn for the four repulsion terms, the wander
// push, the threshold check and the heading normalization
// words: one in flight at a time; the next word may enter while the
// previous result waits in the output register
// reset: threshold 0, period 6000 ms, last wander time -10000 so the first
// word draws a wander direction; output register empty
// output stall: the finished result holds in the final state until the
// output register is free, and tdata/tuser stay stable while m_tvalid waits
module sonar_avoid_wander_heading_core
    import sawh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dist_front, dist_right, dist_back, dist_left, now_ms, rand_x, rand_y
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // heading_x, heading_y
    output logic [31:0]  m_tdata,
    // wander_drawn
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [18:0] {
        S_IDLE    = 19'b0000000000000000001,
        S_REP_G   = 19'b0000000000000000010,
        S_REP_POW = 19'b0000000000000000100,
        S_REP_DIV = 19'b0000000000000001000,
        S_WCHK    = 19'b0000000000000010000,
        S_W_SQX   = 19'b0000000000000100000,
        S_W_SQY   = 19'b0000000000001000000,
        S_W_DIV   = 19'b0000000000010000000,
        S_W_ROOT  = 19'b0000000000100000000,
        S_N_ABS   = 19'b0000000001000000000,
        S_N_SQX   = 19'b0000000010000000000,
        S_N_SQY   = 19'b0000000100000000000,
        S_N_SQT   = 19'b0000001000000000000,
        S_H_SHIFT = 19'b0000010000000000000,
        S_H_SQX   = 19'b0000100000000000000,
        S_H_SQY   = 19'b0001000000000000000,
        S_H_DIV   = 19'b0010000000000000000,
        S_H_ROOT  = 19'b0100000000000000000,
        S_FIN     = 19'b1000000000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration and persistent state
    logic [31:0]        thr_reg, thr_next;
    logic [15:0]        period_reg, period_next;
    logic signed [32:0] last_reg, last_next;

    // latched input word
    logic [3:0][15:0]   dist_reg, dist_next;
    logic [31:0]        now_reg, now_next;
    logic signed [15:0] rx_reg, rx_next;
    logic signed [15:0] ry_reg, ry_next;

    // sequencer bookkeeping
    logic [1:0]  k_reg, k_next;
    logic [1:0]  j_reg, j_next;
    logic        axis_reg, axis_next;
    logic        pend_reg, pend_next;

    // working values
    logic [22:0]         g_reg, g_next;
    logic [127:0]        pw_reg, pw_next;
    logic signed [33:0]  fx_reg, fx_next;
    logic signed [33:0]  fy_reg, fy_next;
    logic [32:0]         ma_reg, ma_next;
    logic [32:0]         mb_reg, mb_next;
    logic [66:0]         sqa_reg, sqa_next;
    logic [66:0]         sqb_reg, sqb_next;
    logic [63:0]         q_reg, q_next;
    logic                drawn_reg, drawn_next;
    logic signed [15:0]  hx_reg, hx_next;
    logic signed [15:0]  hy_reg, hy_next;

    // output register
    logic                ovalid_reg, ovalid_next;
    logic signed [15:0]  ohx_reg, ohx_next;
    logic signed [15:0]  ohy_reg, ohy_next;
    logic                odrawn_reg, odrawn_next;

    // shared unit
    unit_req_t     ureq;
    logic [UW-1:0] uopa;
    logic [UW-1:0] uopb;
    logic          udone;
    logic [UW-1:0] ures;

    logic [67:0]        ssum;
    logic [63:0]        rmag;
    logic [31:0]        rsat;
    logic signed [33:0] elapsed;
    logic [16:0]        wu;
    logic [14:0]        hu;
    logic               calc;

    sawh_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ureq),
        .opa   (uopa),
        .opb   (uopb),
        .done  (udone),
        .res   (ures)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {ohy_reg, ohx_reg};
    assign m_tuser   = odrawn_reg;

    // unit request per state
    always_comb
    begin
        calc = 1'b1;
        uopa = '0;
        uopb = '0;
        ureq.op = OP_MUL;
        unique case (state_reg)
            S_REP_G:
            begin
                uopa = UW'(dist_reg[k_reg]);
                uopb = UW'(REPEL_SCALE);
            end
            S_REP_POW:
            begin
                uopa = UW'(pw_reg);
                uopb = UW'(g_reg);
            end
            S_REP_DIV:
            begin
                ureq.op = OP_DIV;
                uopa    = REPEL_NUM;
                uopb    = UW'(pw_reg);
            end
            S_W_SQX, S_N_SQX, S_H_SQX:
            begin
                uopa = UW'(ma_reg);
                uopb = UW'(ma_reg);
            end
            S_W_SQY, S_N_SQY, S_H_SQY:
            begin
                uopa = UW'(mb_reg);
                uopb = UW'(mb_reg);
            end
            S_N_SQT:
            begin
                uopa = UW'(thr_reg);
                uopb = UW'(thr_reg);
            end
            S_W_DIV:
            begin
                ureq.op = OP_DIV;
                uopa    = UW'(axis_reg ? sqb_reg : sqa_reg) << 32;
                uopb    = UW'(ssum);
            end
            S_H_DIV:
            begin
                ureq.op = OP_DIV;
                uopa    = UW'(axis_reg ? sqb_reg : sqa_reg) << 28;
                uopb    = UW'(ssum);
            end
            S_W_ROOT, S_H_ROOT:
            begin
                ureq.op = OP_SQRT;
                uopa    = UW'(q_reg);
            end
            default:
            begin
                calc = 1'b0;
            end
        endcase
        ureq.start = calc && !pend_reg;
    end

    always_comb
    begin
        ssum    = {1'b0, sqa_reg} + {1'b0, sqb_reg};
        rmag    = (ures[63:0] > FORCE_SAT) ? FORCE_SAT : ures[63:0];
        rsat    = rmag[31:0];
        elapsed = $signed({2'b00, now_reg}) - $signed({last_reg[32], last_reg});
        wu      = ures[16:0];
        hu      = ures[14:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        thr_next    = thr_reg;
        period_next = period_reg;
        last_next   = last_reg;
        dist_next   = dist_reg;
        now_next    = now_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        axis_next   = axis_reg;
        pend_next   = pend_reg;
        g_next      = g_reg;
        pw_next     = pw_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        sqa_next    = sqa_reg;
        sqb_next    = sqb_reg;
        q_next      = q_reg;
        drawn_next  = drawn_reg;
        hx_next     = hx_reg;
        hy_next     = hy_reg;
        ovalid_next = ovalid_reg;
        ohx_next    = ohx_reg;
        ohy_next    = ohy_reg;
        odrawn_next = odrawn_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_next    = cfg_data;
                CFG_PERIOD:    period_next = cfg_data[15:0];
                default:       ;
            endcase
        end

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        if (ureq.start)
        begin
            pend_next = 1'b1;
        end
        else if (udone)
        begin
            pend_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    dist_next[0] = s_tdata[15:0];
                    dist_next[1] = s_tdata[31:16];
                    dist_next[2] = s_tdata[47:32];
                    dist_next[3] = s_tdata[63:48];
                    now_next     = s_tdata[95:64];
                    rx_next      = s_tdata[111:96];
                    ry_next      = s_tdata[127:112];
                    k_next       = '0;
                    fx_next      = '0;
                    fy_next      = '0;
                    hx_next      = '0;
                    hy_next      = '0;
                    drawn_next   = 1'b0;
                    state_next   = S_REP_G;
                end
            end
            S_REP_G:
            begin
                if (udone)
                begin
                    g_next     = ures[22:0] + REPEL_BIAS;
                    pw_next    = 128'(ures[22:0] + REPEL_BIAS);
                    j_next     = '0;
                    state_next = S_REP_POW;
                end
            end
            S_REP_POW:
            begin
                // g^2 .. g^5
                if (udone)
                begin
                    pw_next = ures[127:0];
                    j_next  = j_reg + 2'd1;
                    if (j_reg == 2'd3)
                    begin
                        state_next = S_REP_DIV;
                    end
                end
            end
            S_REP_DIV:
            begin
                if (udone)
                begin
                    // front pushes -y, right -x, back +y, left +x
                    case (k_reg)
                        2'd0:    fy_next = fy_reg - $signed({2'b00, rsat});
                        2'd1:    fx_next = fx_reg - $signed({2'b00, rsat});
                        2'd2:    fy_next = fy_reg + $signed({2'b00, rsat});
                        default: fx_next = fx_reg + $signed({2'b00, rsat});
                    endcase
                    k_next = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_WCHK : S_REP_G;
                end
            end
            S_WCHK:
            begin
                if (elapsed >= $signed({18'd0, period_reg}))
                begin
                    drawn_next = 1'b1;
                    last_next  = $signed({1'b0, now_reg});
                    ma_next    = 33'(({rx_reg[15], rx_reg} ^ {17{rx_reg[15]}})
                                     + 17'(rx_reg[15]));
                    mb_next    = 33'(({ry_reg[15], ry_reg} ^ {17{ry_reg[15]}})
                                     + 17'(ry_reg[15]));
                    // zero random vector: heading stays zero
                    state_next = (rx_reg == '0 && ry_reg == '0) ? S_FIN : S_W_SQX;
                end
                else
                begin
                    state_next = S_N_ABS;
                end
            end
            S_W_SQX:
            begin
                if (udone)
                begin
                    sqa_next   = ures[66:0];
                    state_next = S_W_SQY;
                end
            end
            S_W_SQY:
            begin
                if (udone)
                begin
                    sqb_next   = ures[66:0];
                    axis_next  = 1'b0;
                    state_next = S_W_DIV;
                end
            end
            S_W_DIV:
            begin
                if (udone)
                begin
                    q_next     = ures[63:0];
                    state_next = S_W_ROOT;
                end
            end
            S_W_ROOT:
            begin
                if (udone)
                begin
                    if (!axis_reg)
                    begin
                        fx_next = rx_reg[15] ? fx_reg - $signed({17'd0, wu})
                                             : fx_reg + $signed({17'd0, wu});
                        axis_next  = 1'b1;
                        state_next = S_W_DIV;
                    end
                    else
                    begin
                        fy_next = ry_reg[15] ? fy_reg - $signed({17'd0, wu})
                                             : fy_reg + $signed({17'd0, wu});
                        state_next = S_N_ABS;
                    end
                end
            end
            S_N_ABS:
            begin
                ma_next    = 33'((fx_reg ^ {34{fx_reg[33]}}) + 34'(fx_reg[33]));
                mb_next    = 33'((fy_reg ^ {34{fy_reg[33]}}) + 34'(fy_reg[33]));
                state_next = S_N_SQX;
            end
            S_N_SQX:
            begin
                if (udone)
                begin
                    sqa_next   = ures[66:0];
                    state_next = S_N_SQY;
                end
            end
            S_N_SQY:
            begin
                if (udone)
                begin
                    sqb_next   = ures[66:0];
                    state_next = S_N_SQT;
                end
            end
            S_N_SQT:
            begin
                // strict compare of the squared norm against threshold squared
                if (udone)
                begin
                    state_next = (ssum > 68'(ures[63:0])) ? S_H_SHIFT : S_FIN;
                end
            end
            S_H_SHIFT:
            begin
                if (ma_reg[32:17] != '0 || mb_reg[32:17] != '0)
                begin
                    ma_next = ma_reg >> 1;
                    mb_next = mb_reg >> 1;
                end
                else
                begin
                    state_next = S_H_SQX;
                end
            end
            S_H_SQX:
            begin
                if (udone)
                begin
                    sqa_next   = ures[66:0];
                    state_next = S_H_SQY;
                end
            end
            S_H_SQY:
            begin
                if (udone)
                begin
                    sqb_next   = ures[66:0];
                    axis_next  = 1'b0;
                    state_next = (ures[66:0] == '0 && sqa_reg == '0) ? S_FIN : S_H_DIV;
                end
            end
            S_H_DIV:
            begin
                if (udone)
                begin
                    q_next     = ures[63:0];
                    state_next = S_H_ROOT;
                end
            end
            S_H_ROOT:
            begin
                if (udone)
                begin
                    if (!axis_reg)
                    begin
                        hx_next = fx_reg[33] ? -$signed({1'b0, hu}) : $signed({1'b0, hu});
                        axis_next  = 1'b1;
                        state_next = S_H_DIV;
                    end
                    else
                    begin
                        hy_next = fy_reg[33] ? -$signed({1'b0, hu}) : $signed({1'b0, hu});
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    ohx_next    = hx_reg;
                    ohy_next    = hy_reg;
                    odrawn_next = drawn_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            thr_reg    <= '0;
            period_reg <= PERIOD_RESET;
            last_reg   <= LAST_RESET;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            thr_reg    <= thr_next;
            period_reg <= period_next;
            last_reg   <= last_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg   <= dist_next;
        now_reg    <= now_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        axis_reg   <= axis_next;
        g_reg      <= g_next;
        pw_reg     <= pw_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        sqa_reg    <= sqa_next;
        sqb_reg    <= sqb_next;
        q_reg      <= q_next;
        drawn_reg  <= drawn_next;
        hx_reg     <= hx_next;
        hy_reg     <= hy_next;
        ohx_reg    <= ohx_next;
        ohy_reg    <= ohy_next;
        odrawn_reg <= odrawn_next;
    end

endmodule
